// File: rtl/core/lla_pkg.sv
package lla_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int TIME_W   = 48;
  localparam int ADDR_W   = 48;
  localparam int CORE_W   = 8;
  localparam int TASK_W   = 16;
  localparam int CHIP_W   = 4;
  localparam int SIZE_W   = 13;
  localparam int EXTRA_W  = 16;
  localparam int BASE_W   = 10;
  localparam int WIDTH_W  = 9;
  localparam int PEN_W    = 10;
  localparam int LAT_W    = 14;
  localparam int QCNT_W   = 5;
  localparam int OP_W     = 2;
  localparam int STEP_W   = $clog2(SIZE_W);

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam int IN_DATA_W  = 160;
  localparam int OUT_DATA_W = 232;

  localparam logic [BASE_W-1:0]  BASE_LATENCY_RST   = BASE_W'(1);
  localparam logic [WIDTH_W-1:0] LINK_WIDTH_RST     = WIDTH_W'(32);
  localparam logic [PEN_W-1:0]   REMOTE_PENALTY_RST = PEN_W'(0);

  typedef enum logic [OP_W-1:0] {
    OP_ENQUEUE   = 2'd0,
    OP_ARBITRATE = 2'd1,
    OP_ADD_BUSY  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    REG_BASE_LATENCY   = 2'd0,
    REG_LINK_WIDTH     = 2'd1,
    REG_REMOTE_PENALTY = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_LAT,
    ST_COMMIT
  } state_t;

  // Input beat payload, last member in the lowest bits.
  typedef struct packed {
    logic [1:0]         pad;
    logic [EXTRA_W-1:0] extra_cycles;
    logic [TIME_W-1:0]  now_time;
    logic [SIZE_W-1:0]  data_size;
    logic [CHIP_W-1:0]  dst_chiplet;
    logic [CHIP_W-1:0]  src_chiplet;
    logic [TASK_W-1:0]  req_task;
    logic [CORE_W-1:0]  req_core;
    logic               req_is_write;
    logic [ADDR_W-1:0]  req_address;
  } in_data_t;

  typedef struct packed {
    logic [6:0]        pad;
    logic [TIME_W-1:0] busy_cycle_total;
    logic [TIME_W-1:0] transfer_total;
    logic              enqueue_dropped;
    logic [QCNT_W-1:0] queued_count;
    logic              link_available;
    logic              link_busy;
    logic [TASK_W-1:0] grant_task;
    logic [CORE_W-1:0] grant_core;
    logic              grant_is_write;
    logic [ADDR_W-1:0] grant_address;
    logic [TIME_W-1:0] completion_time;
  } out_data_t;

  typedef struct packed {
    logic [SIZE_W-1:0] data_size;
    logic [CHIP_W-1:0] dst_chiplet;
    logic [CHIP_W-1:0] src_chiplet;
    logic [TASK_W-1:0] req_task;
    logic [CORE_W-1:0] req_core;
    logic              req_is_write;
    logic [ADDR_W-1:0] req_address;
  } entry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_sts_t;

  typedef struct packed {
    logic               start;
    logic [SIZE_W-1:0]  dividend;
    logic [WIDTH_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [SIZE_W-1:0] quotient;
    logic              inexact;
  } div_rsp_t;

endpackage

// File: rtl/core/lla_queue.sv
module lla_queue #(
  parameter int DEPTH = lla_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  lla_pkg::q_ctl_t            ctl,
  input  lla_pkg::entry_t            wr_entry,
  output lla_pkg::entry_t            head_entry,
  output lla_pkg::q_sts_t            sts,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  import lla_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t mem [DEPTH];

  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else if (ctl.push) begin
      tail  <= wrap_inc(tail);
      count <= count + CNT_W'(1);
    end else if (ctl.pop) begin
      head  <= wrap_inc(head);
      count <= count - CNT_W'(1);
    end
  end

  // The head entry is registered from the memory every cycle; after the head
  // pointer or the memory changes, the sequencer passes through idle before using it.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail] <= wr_entry;
    end
    head_entry <= mem[head];
  end

  assign sts.empty = (count == '0);
  assign sts.full  = (count == CNT_W'(DEPTH));

endmodule

// File: rtl/core/lla_div.sv
module lla_div (
  input  logic              clk,
  input  logic              rst,
  input  lla_pkg::div_req_t req,
  output lla_pkg::div_rsp_t rsp
);
  import lla_pkg::*;

  logic               active;
  logic               done;
  logic [STEP_W-1:0]  step;
  logic [WIDTH_W-1:0] rem;
  logic [SIZE_W-1:0]  quo;
  logic [WIDTH_W-1:0] dvsr;

  logic [WIDTH_W:0] trial;
  logic [WIDTH_W:0] diff;
  logic             fits;

  // One quotient bit per cycle, most significant first.
  assign trial = {rem, quo[SIZE_W-1]};
  assign diff  = trial - {1'b0, dvsr};
  assign fits  = !diff[WIDTH_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      step   <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        active <= 1'b1;
        step   <= '0;
      end else if (active) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(SIZE_W - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= '0;
      quo  <= req.dividend;
      dvsr <= req.divisor;
    end else if (active) begin
      rem <= fits ? diff[WIDTH_W-1:0] : trial[WIDTH_W-1:0];
      quo <= {quo[SIZE_W-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;
  assign rsp.inexact  = |rem;

endmodule

// File: rtl/core/fifo_link_latency_arbiter.sv
// Link arbiter with a first-in, first-out request queue.
// Input beats on the s_ channel carry an operation in s_tuser: enqueue a
// request, arbitrate (grant the oldest request) or add busy cycles. Every
// input beat gives exactly one result beat on the m_ channel, carrying the
// grant, its completion time and the link status after the operation.
// Items are handled one at a time. Enqueue, add-busy and arbitrate on an
// empty queue go from acceptance straight to the final update, which
// registers the result; the next beat is taken once the sequencer is idle
// again. Arbitrate with a waiting request passes through a start step, the
// serial divider that forms the ceiling of data size over link width one
// quotient bit at a time, a step to see the divider finish, the latency sum
// and the final update.
// s_tready is high only while the sequencer is idle; the result sits in an
// output register, so a new beat is accepted while the last result waits.
// If the receiver stalls with a result still held, the next result waits in
// its final step until the output register is free.
// Reset empties the queue, clears busy state and counters and loads the
// register defaults; queue storage itself is not cleared.
// Registers on the APB port: base latency at 0x0, link width at 0x4 and
// remote penalty at 0x8; write them only while the block is idle.
module fifo_link_latency_arbiter #(
  parameter int QUEUE_DEPTH = lla_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // req_address, req_is_write, req_core, req_task, src_chiplet,
  // dst_chiplet, data_size, now_time, extra_cycles, zero pad
  input  logic [lla_pkg::IN_DATA_W-1:0]    s_tdata,
  // operation
  input  logic [lla_pkg::OP_W-1:0]         s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // completion_time, grant_address, grant_is_write, grant_core, grant_task,
  // link_busy, link_available, queued_count, enqueue_dropped,
  // transfer_total, busy_cycle_total, zero pad
  output logic [lla_pkg::OUT_DATA_W-1:0]   m_tdata,
  // granted
  output logic [0:0]                       m_tuser,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lla_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [lla_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [lla_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import lla_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Configuration registers.
  logic [BASE_W-1:0]  base_latency;
  logic [WIDTH_W-1:0] link_width;
  logic [PEN_W-1:0]   remote_penalty;
  reg_idx_t           reg_idx;
  logic               cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_latency   <= BASE_LATENCY_RST;
      link_width     <= LINK_WIDTH_RST;
      remote_penalty <= REMOTE_PENALTY_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_BASE_LATENCY:   base_latency   <= pwdata[BASE_W-1:0];
        REG_LINK_WIDTH:     link_width     <= pwdata[WIDTH_W-1:0];
        REG_REMOTE_PENALTY: remote_penalty <= pwdata[PEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BASE_LATENCY:   prdata = APB_DATA_W'(base_latency);
      REG_LINK_WIDTH:     prdata = APB_DATA_W'(link_width);
      REG_REMOTE_PENALTY: prdata = APB_DATA_W'(remote_penalty);
      default:            prdata = '0;
    endcase
  end

  // Sequencer and held item.
  state_t   state;
  state_t   state_next;
  in_data_t din;
  in_data_t item;
  op_t      op_in;
  op_t      op_reg;
  logic     commit;

  // Queue.
  q_ctl_t           q_ctl;
  q_sts_t           q_sts;
  entry_t           wr_entry;
  entry_t           head_entry;
  logic [CNT_W-1:0] q_count;
  logic             push;
  logic             pop;

  // Serial divider.
  div_req_t div_req;
  div_rsp_t div_rsp;

  // Link state.
  logic              busy;
  logic              busy_next;
  logic [TIME_W-1:0] transfer_total;
  logic [TIME_W-1:0] transfer_next;
  logic [TIME_W-1:0] busy_sum;
  logic [TIME_W-1:0] busy_sum_next;
  logic [LAT_W-1:0]  lat;
  logic [LAT_W-1:0]  lat_next;
  logic [CNT_W-1:0]  cnt_after;

  out_data_t out_reg;
  out_data_t out_next;
  logic      granted_reg;
  logic      granted_next;

  assign din      = in_data_t'(s_tdata);
  assign op_in    = op_t'(s_tuser);
  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item   <= din;
      op_reg <= op_in;
    end
  end

  always_comb begin
    state_next       = state;
    commit           = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = head_entry.data_size;
    div_req.divisor  = link_width;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = (op_in == OP_ARBITRATE && !q_sts.empty) ? ST_LOAD : ST_COMMIT;
        end
      end
      ST_LOAD: begin
        div_req.start = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_next = ST_LAT;
        end
      end
      ST_LAT: begin
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (!m_tvalid || m_tready) begin
          commit     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // A zero link width means no serialisation term at all.
  always_comb begin
    lat_next = LAT_W'(base_latency);
    if (link_width != '0) begin
      lat_next = lat_next + LAT_W'(div_rsp.quotient) + LAT_W'(div_rsp.inexact);
    end
    if (head_entry.src_chiplet != head_entry.dst_chiplet) begin
      lat_next = lat_next + LAT_W'(remote_penalty);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_LAT) begin
      lat <= lat_next;
    end
  end

  always_comb begin
    push          = 1'b0;
    pop           = 1'b0;
    busy_next     = busy;
    transfer_next = transfer_total;
    busy_sum_next = busy_sum;
    cnt_after     = q_count;
    granted_next  = 1'b0;
    out_next      = '0;
    case (op_reg)
      OP_ENQUEUE: begin
        if (q_sts.full) begin
          out_next.enqueue_dropped = 1'b1;
        end else begin
          push      = 1'b1;
          cnt_after = q_count + CNT_W'(1);
        end
      end
      OP_ARBITRATE: begin
        if (q_sts.empty) begin
          busy_next = 1'b0;
        end else begin
          pop                      = 1'b1;
          cnt_after                = q_count - CNT_W'(1);
          busy_next                = 1'b1;
          granted_next             = 1'b1;
          transfer_next            = transfer_total + TIME_W'(1);
          busy_sum_next            = busy_sum + TIME_W'(lat);
          out_next.completion_time = item.now_time + TIME_W'(lat);
          out_next.grant_address   = head_entry.req_address;
          out_next.grant_is_write  = head_entry.req_is_write;
          out_next.grant_core      = head_entry.req_core;
          out_next.grant_task      = head_entry.req_task;
        end
      end
      OP_ADD_BUSY: begin
        busy_sum_next = busy_sum + TIME_W'(item.extra_cycles);
      end
      default: ;
    endcase
    out_next.link_busy        = busy_next;
    out_next.link_available   = !busy_next && (cnt_after == '0);
    out_next.queued_count     = QCNT_W'(cnt_after);
    out_next.transfer_total   = transfer_next;
    out_next.busy_cycle_total = busy_sum_next;
  end

  assign q_ctl.push = commit && push;
  assign q_ctl.pop  = commit && pop;

  assign wr_entry.data_size    = item.data_size;
  assign wr_entry.dst_chiplet  = item.dst_chiplet;
  assign wr_entry.src_chiplet  = item.src_chiplet;
  assign wr_entry.req_task     = item.req_task;
  assign wr_entry.req_core     = item.req_core;
  assign wr_entry.req_is_write = item.req_is_write;
  assign wr_entry.req_address  = item.req_address;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy           <= 1'b0;
      transfer_total <= '0;
      busy_sum       <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      if (commit) begin
        busy           <= busy_next;
        transfer_total <= transfer_next;
        busy_sum       <= busy_sum_next;
        m_tvalid       <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_reg     <= out_next;
      granted_reg <= granted_next;
    end
  end

  assign m_tdata    = OUT_DATA_W'(out_reg);
  assign m_tuser[0] = granted_reg;

  lla_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .ctl        (q_ctl),
    .wr_entry   (wr_entry),
    .head_entry (head_entry),
    .sts        (q_sts),
    .count      (q_count)
  );

  lla_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item accepted while one is in progress");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == ST_DIV)
    else $error("divider finished outside the division step");

  a_grant_busy: assert property (@(posedge clk) disable iff (rst)
    commit && granted_next |=> m_tvalid && busy && !out_reg.link_available)
    else $error("grant reported without the link marked busy");

endmodule

// File: dv/fifo_link_latency_arbiter_tb.sv
`timescale 1ns / 1ps

module fifo_link_latency_arbiter_tb;
  import lla_pkg::*;

  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD = 400;
  localparam int TAIL_CYCLES = 24;
  localparam int ITEMS_PER_PHASE = 67;
  localparam int PHASES = 6;

  typedef struct {
    logic      granted;
    out_data_t fields;
  } grant_report_t;

  class link_grant_board;
    logic [BASE_W-1:0]  base_lat;
    logic [WIDTH_W-1:0] link_width;
    logic [PEN_W-1:0]   penalty;
    entry_t             slots[QUEUE_DEPTH_DEF];
    int                 head;
    int                 tail;
    int                 fill;
    logic               busy;
    logic [TIME_W-1:0]  busy_until;
    logic [TIME_W-1:0]  grants;
    logic [TIME_W-1:0]  busy_sum;
    grant_report_t      awaited[$];
    int                 errors;

    function new();
      base_lat   = BASE_LATENCY_RST;
      link_width = LINK_WIDTH_RST;
      penalty    = REMOTE_PENALTY_RST;
      head       = 0;
      tail       = 0;
      fill       = 0;
      busy       = 1'b0;
      busy_until = '0;
      grants     = '0;
      busy_sum   = '0;
      errors     = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [APB_DATA_W-1:0] value);
      case (idx)
        REG_BASE_LATENCY:   base_lat = value[BASE_W-1:0];
        REG_LINK_WIDTH:     link_width = value[WIDTH_W-1:0];
        REG_REMOTE_PENALTY: penalty = value[PEN_W-1:0];
        default: ;
      endcase
    endfunction

    // Works out the result beat that one accepted input beat must produce.
    function void note_item(logic [OP_W-1:0] op, in_data_t d);
      grant_report_t r;
      entry_t        e;
      logic [63:0]   lat;
      r.granted = 1'b0;
      r.fields = '0;
      case (op)
        OP_ENQUEUE: begin
          if (fill >= QUEUE_DEPTH_DEF) begin
            r.fields.enqueue_dropped = 1'b1;
          end else begin
            e.req_address  = d.req_address;
            e.req_is_write = d.req_is_write;
            e.req_core     = d.req_core;
            e.req_task     = d.req_task;
            e.src_chiplet  = d.src_chiplet;
            e.dst_chiplet  = d.dst_chiplet;
            e.data_size    = d.data_size;
            slots[tail] = e;
            tail = (tail + 1) % QUEUE_DEPTH_DEF;
            fill++;
          end
        end
        OP_ARBITRATE: begin
          if (fill == 0) begin
            busy = 1'b0;
            busy_until = '0;
          end else begin
            e = slots[head];
            head = (head + 1) % QUEUE_DEPTH_DEF;
            fill--;
            lat = 64'(base_lat);
            if (link_width != 0)
              lat += (64'(e.data_size) + 64'(link_width) - 64'd1) / 64'(link_width);
            if (e.src_chiplet != e.dst_chiplet)
              lat += 64'(penalty);
            busy = 1'b1;
            busy_until = d.now_time + lat[TIME_W-1:0];
            grants = grants + TIME_W'(1);
            busy_sum = busy_sum + lat[TIME_W-1:0];
            r.granted = 1'b1;
            r.fields.completion_time = busy_until;
            r.fields.grant_address   = e.req_address;
            r.fields.grant_is_write  = e.req_is_write;
            r.fields.grant_core      = e.req_core;
            r.fields.grant_task      = e.req_task;
          end
        end
        OP_ADD_BUSY: busy_sum = busy_sum + TIME_W'(d.extra_cycles);
        default: ;
      endcase
      r.fields.link_busy        = busy;
      r.fields.link_available   = !busy && (fill == 0);
      r.fields.queued_count     = QCNT_W'(fill);
      r.fields.transfer_total   = grants;
      r.fields.busy_cycle_total = busy_sum;
      awaited.push_back(r);
    endfunction

    function void compare(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_report(logic granted, out_data_t o);
      grant_report_t r;
      if (awaited.size() == 0) begin
        $display("%0t: result beat with nothing awaited, actual %0h", $time, o);
        errors++;
        return;
      end
      r = awaited.pop_front();
      compare("granted", 64'(r.granted), 64'(granted));
      compare("completion_time", 64'(r.fields.completion_time), 64'(o.completion_time));
      compare("grant_address", 64'(r.fields.grant_address), 64'(o.grant_address));
      compare("grant_is_write", 64'(r.fields.grant_is_write), 64'(o.grant_is_write));
      compare("grant_core", 64'(r.fields.grant_core), 64'(o.grant_core));
      compare("grant_task", 64'(r.fields.grant_task), 64'(o.grant_task));
      compare("link_busy", 64'(r.fields.link_busy), 64'(o.link_busy));
      compare("link_available", 64'(r.fields.link_available), 64'(o.link_available));
      compare("queued_count", 64'(r.fields.queued_count), 64'(o.queued_count));
      compare("enqueue_dropped", 64'(r.fields.enqueue_dropped), 64'(o.enqueue_dropped));
      compare("transfer_total", 64'(r.fields.transfer_total), 64'(o.transfer_total));
      compare("busy_cycle_total", 64'(r.fields.busy_cycle_total),
              64'(o.busy_cycle_total));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [OP_W-1:0]       s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [0:0]            m_tuser;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  link_grant_board board = new();
  int  cycles = 0;
  int  tx_max_gap = 13;
  int  rx_max_stall = 13;
  bit  hold_output = 1'b0;

  fifo_link_latency_arbiter u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[fifo_link_latency_arbiter] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      board.check_report(m_tuser[0], out_data_t'(m_tdata));
  end

  // The receiver draws a stall before every beat; a long hold-off is taken when asked.
  initial begin : rx_side
    int stall;
    forever begin
      if (hold_output) begin
        stall = LONG_HOLD;
        hold_output = 1'b0;
      end else begin
        stall = $urandom_range(0, rx_max_stall);
      end
      m_tready <= (stall == 0);
      if (stall != 0) begin
        repeat (stall) @(posedge clk);
        m_tready <= 1'b1;
      end
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  function automatic in_data_t random_fields();
    in_data_t d;
    d = '0;
    d.req_address  = ADDR_W'({$urandom, $urandom});
    d.req_is_write = 1'($urandom_range(0, 1));
    d.req_core     = CORE_W'($urandom);
    d.req_task     = TASK_W'($urandom);
    d.src_chiplet  = CHIP_W'($urandom);
    d.dst_chiplet  = $urandom_range(0, 1) ? d.src_chiplet : CHIP_W'($urandom);
    case ($urandom_range(0, 9))
      0:       d.data_size = '0;
      1:       d.data_size = SIZE_W'(4096);
      2:       d.data_size = SIZE_W'($urandom_range(4097, 8191));
      default: d.data_size = SIZE_W'($urandom_range(0, 4096));
    endcase
    d.now_time     = ($urandom_range(0, 15) == 0) ? '1 : TIME_W'({$urandom, $urandom});
    d.extra_cycles = EXTRA_W'($urandom);
    return d;
  endfunction

  task automatic send_item(logic [OP_W-1:0] op, in_data_t d);
    int gap;
    gap = $urandom_range(0, tx_max_gap);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tuser  <= op;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    board.note_item(op, d);
  endtask

  task automatic settle(int extra);
    s_tvalid <= 1'b0;
    while (board.awaited.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.set_reg(idx, value);
    @(posedge clk);
  endtask

  initial begin
    in_data_t        d;
    logic [OP_W-1:0] op;
    int              phase;
    int              sent;
    int              pick;
    int              enq_pct[PHASES] = '{45, 60, 40, 55, 35, 45};

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty-queue arbitration, the unused operation code and extreme busy cycles.
    d = random_fields();
    send_item(OP_ARBITRATE, d);
    send_item(OP_RESERVED, random_fields());
    d.extra_cycles = '0;
    send_item(OP_ADD_BUSY, d);
    d.extra_cycles = '1;
    send_item(OP_ADD_BUSY, d);

    d = '0;
    d.req_address  = '1;
    d.req_is_write = 1'b1;
    d.req_core     = '1;
    d.req_task     = '1;
    d.src_chiplet  = '1;
    d.data_size    = SIZE_W'(4096);
    send_item(OP_ENQUEUE, d);
    send_item(OP_ENQUEUE, '0);
    d = random_fields();
    d.data_size = '1;
    send_item(OP_ENQUEUE, d);
    // Fill the queue and push once more so that a request is dropped.
    repeat (14) send_item(OP_ENQUEUE, random_fields());

    // The first grant wraps its completion time past the top of the 48-bit range.
    d = random_fields();
    d.now_time = '1;
    send_item(OP_ARBITRATE, d);
    d.now_time = '0;
    send_item(OP_ARBITRATE, d);
    send_item(OP_ARBITRATE, random_fields());

    for (phase = 0; phase < PHASES; phase++) begin
      if (phase != 0) begin
        settle(TAIL_CYCLES);
        case (phase)
          1: begin
            write_reg(REG_BASE_LATENCY, 32'd0);
            write_reg(REG_LINK_WIDTH, 32'd0);
            write_reg(REG_REMOTE_PENALTY, 32'd0);
          end
          2: begin
            write_reg(REG_BASE_LATENCY, 32'd1023);
            write_reg(REG_LINK_WIDTH, 32'd256);
            write_reg(REG_REMOTE_PENALTY, 32'd1023);
          end
          3: write_reg(REG_LINK_WIDTH, 32'd1);
          4: begin
            write_reg(REG_BASE_LATENCY, $urandom_range(0, 1023));
            write_reg(REG_LINK_WIDTH, 32'd511);
            write_reg(REG_REMOTE_PENALTY, $urandom_range(0, 1023));
          end
          default: begin
            write_reg(REG_BASE_LATENCY, $urandom_range(0, 1023));
            write_reg(REG_LINK_WIDTH, $urandom_range(1, 256));
            write_reg(REG_REMOTE_PENALTY, $urandom_range(0, 1023));
          end
        endcase
      end
      // One phase runs with no idling on either side.
      tx_max_gap   = (phase == 2) ? 0 : 13;
      rx_max_stall = (phase == 2) ? 0 : 13;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        if (phase == 3 && sent == 10)
          hold_output = 1'b1;
        if (phase == 4 && sent == 40)
          settle(0);
        pick = $urandom_range(0, 99);
        if (pick < enq_pct[phase])
          op = OP_ENQUEUE;
        else if (pick < 88)
          op = OP_ARBITRATE;
        else if (pick < 96)
          op = OP_ADD_BUSY;
        else
          op = OP_RESERVED;
        send_item(op, random_fields());
        if (op != OP_RESERVED)
          sent++;
      end
    end

    settle(TAIL_CYCLES);
    if (board.errors == 0 && board.awaited.size() == 0) begin
      $display("[fifo_link_latency_arbiter] OK");
    end else begin
      $display("[fifo_link_latency_arbiter] ERROR");
    end
    $finish;
  end

endmodule
